// ----- rtl/mpmc_pkg.sv -----
`timescale 1ns / 1ps

package mpmc_pkg;

  // sizes of the automaton
  localparam int MAX_NODES    = 2048;
  localparam int MAX_PATTERNS = 32;
  localparam int ALPHABET     = 26;
  localparam int COUNT_BITS   = 20;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
  localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
  localparam int PAT_W      = 6;
  localparam int PIDX_W     = $clog2(MAX_PATTERNS);
  localparam int SYM_W      = 5;
  localparam int QCNT_W     = NODE_W + 1;

  // item operation codes
  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_BUILD   = 2'd1,
    OP_TEXT    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] top_count;
    logic [PAT_W-1:0]      pattern_index;
    logic                  overflow;
    logic                  last_result;
  } out_t;

endpackage

// ----- rtl/multi_pattern_match_counter.sv -----
`timescale 1ns / 1ps

// Aho-Corasick matcher, one item at a time: an item is taken when start is high and busy is
// low, and busy stays high until all of its work is done. After reset and after a clear item
// the block sweeps its goto memory (one entry a cycle) before it takes the next item. A
// pattern letter does one goto read, then the update; a skipped letter is done as it is taken.
// A build queues the children of the root, then walks the trie breadth-first, reading two
// goto entries at once for each letter of each node. A text letter does one goto read, then
// a hit counter read-modify-write for each node on the fail chain of the new state; a letter
// outside the alphabet resets the state as it is taken. The last text letter then reports: a
// setup step and two passes over the end-node and hit memories for the loaded patterns,
// followed by a sweep that clears all 2048 hit counters. Results leave on out_item with
// out_valid high for one cycle each; the receiver must take each one as it comes, since the
// block cannot hold a result back.
module multi_pattern_match_counter
  import mpmc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_CLR  = 18'h00002,
    S_PCHK = 18'h00004,
    S_TGO  = 18'h00008,
    S_HUPD = 18'h00010,
    S_RP   = 18'h00020,
    S_RH   = 18'h00040,
    S_RC   = 18'h00080,
    S_HCLR = 18'h00100,
    S_BR   = 18'h00200,
    S_BRC  = 18'h00400,
    S_BH   = 18'h00800,
    S_BU   = 18'h01000,
    S_BF   = 18'h02000,
    S_BE   = 18'h04000,
    S_BEC  = 18'h08000,
    S_RPT  = 18'h10000,
    S_TEND = 18'h20000
  } state_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // memories
  logic [NODE_W-1:0]     goto_mem  [GOTO_DEPTH];
  logic [NODE_W-1:0]     fail_mem  [MAX_NODES];
  logic [COUNT_BITS-1:0] hits_mem  [MAX_NODES];
  logic [NODE_W-1:0]     pend_mem  [MAX_PATTERNS];
  logic [NODE_W-1:0]     queue_mem [MAX_NODES];

  logic [NODE_W-1:0]     goto_rd1, goto_rd2, fail_rd, pend_rd, queue_rd;
  logic [COUNT_BITS-1:0] hits_rd;

  logic                  goto_we, fail_we, hits_we, pend_we, queue_we;
  logic [GOTO_AW-1:0]    goto_ra1, goto_ra2, goto_wa;
  logic [NODE_W-1:0]     goto_wd, fail_ra, fail_wa, fail_wd, hits_ra, hits_wa;
  logic [COUNT_BITS-1:0] hits_wd;
  logic [PIDX_W-1:0]     pend_ra, pend_wa;
  logic [NODE_W-1:0]     pend_wd, queue_ra, queue_wa, queue_wd;

  // control registers
  state_t                state_r, state_nxt;
  logic [NODE_W-1:0]     node_total_r, node_total_nxt;
  logic [PAT_W-1:0]      pattern_total_r, pattern_total_nxt;
  logic [NODE_W-1:0]     cursor_r, cursor_nxt;
  logic [NODE_W-1:0]     match_r, match_nxt;
  logic                  overflow_r, overflow_nxt;
  logic                  built_r, built_nxt;
  logic                  dropping_r, dropping_nxt;
  logic                  last_r, last_nxt;
  logic [GOTO_AW-1:0]    gaddr_r, gaddr_nxt;
  logic [GOTO_AW-1:0]    cnt_r, cnt_nxt;
  logic [NODE_W-1:0]     p_r, p_nxt;
  logic [PAT_W-1:0]      i_r, i_nxt;
  logic                  pass_r, pass_nxt;
  logic [COUNT_BITS-1:0] best_r, best_nxt;
  logic [PAT_W-1:0]      lastidx_r, lastidx_nxt;
  logic [SYM_W-1:0]      c_r, c_nxt;
  logic [QCNT_W-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [NODE_W-1:0]     u_r, u_nxt, f_r, f_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_item_r, out_item_nxt;

  function automatic logic [GOTO_AW-1:0] row_addr(input logic [NODE_W-1:0] node,
                                                  input logic [SYM_W-1:0] sym);
    row_addr = GOTO_AW'(node) * GOTO_AW'(ALPHABET) + GOTO_AW'(sym);
  endfunction

  // memory ports
  always_ff @(posedge clk) begin
    if (goto_we) goto_mem[goto_wa] <= goto_wd;
    goto_rd1 <= goto_mem[goto_ra1];
    goto_rd2 <= goto_mem[goto_ra2];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk) begin
    if (hits_we) hits_mem[hits_wa] <= hits_wd;
    hits_rd <= hits_mem[hits_ra];
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd <= pend_mem[pend_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd <= queue_mem[queue_ra];
  end

  // next state and memory control
  always_comb begin
    logic                  drop;
    logic [NODE_W-1:0]     cur;
    logic [COUNT_BITS-1:0] h;
    logic                  do_close;
    logic                  do_text_end;
    state_nxt         = state_r;
    node_total_nxt    = node_total_r;
    pattern_total_nxt = pattern_total_r;
    cursor_nxt        = cursor_r;
    match_nxt         = match_r;
    overflow_nxt      = overflow_r;
    built_nxt         = built_r;
    dropping_nxt      = dropping_r;
    last_nxt          = last_r;
    gaddr_nxt         = gaddr_r;
    cnt_nxt           = cnt_r;
    p_nxt             = p_r;
    i_nxt             = i_r;
    pass_nxt          = pass_r;
    best_nxt          = best_r;
    lastidx_nxt       = lastidx_r;
    c_nxt             = c_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    u_nxt             = u_r;
    f_nxt             = f_r;
    out_valid_nxt     = 1'b0;
    out_item_nxt      = out_item_r;
    goto_we  = 1'b0;
    goto_ra1 = '0;
    goto_ra2 = '0;
    goto_wa  = gaddr_r;
    goto_wd  = '0;
    fail_we  = 1'b0;
    fail_ra  = '0;
    fail_wa  = '0;
    fail_wd  = '0;
    hits_we  = 1'b0;
    hits_ra  = '0;
    hits_wa  = '0;
    hits_wd  = '0;
    pend_we  = 1'b0;
    pend_ra  = i_r[PIDX_W-1:0];
    pend_wa  = pattern_total_r[PIDX_W-1:0];
    pend_wd  = '0;
    queue_we = 1'b0;
    queue_ra = head_r[NODE_W-1:0];
    queue_wa = tail_r[NODE_W-1:0];
    queue_wd = '0;
    drop     = dropping_r;
    cur      = cursor_r;
    h        = '0;
    do_close = 1'b0;
    do_text_end = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          last_nxt = in_item.last;
          unique case (in_item.op)
            OP_PATTERN: begin
              if (!built_r) begin
                if (!dropping_r && in_item.symbol < SYM_W'(ALPHABET)) begin
                  goto_ra1  = row_addr(cursor_r, in_item.symbol);
                  gaddr_nxt = goto_ra1;
                  state_nxt = S_PCHK;
                end else begin
                  do_close = in_item.last;
                end
              end
            end
            OP_BUILD: begin
              if (!built_r) begin
                built_nxt = 1'b1;
                c_nxt     = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
                state_nxt = S_BR;
              end
            end
            OP_TEXT: begin
              if (in_item.symbol < SYM_W'(ALPHABET)) begin
                goto_ra1  = row_addr(match_r, in_item.symbol);
                state_nxt = S_TGO;
              end else begin
                match_nxt = '0;
                state_nxt = in_item.last ? S_RPT : S_IDLE;
              end
            end
            OP_CLEAR: begin
              node_total_nxt    = '0;
              pattern_total_nxt = '0;
              cursor_nxt        = '0;
              match_nxt         = '0;
              overflow_nxt      = 1'b0;
              built_nxt         = 1'b0;
              dropping_nxt      = 1'b0;
              cnt_nxt           = '0;
              state_nxt         = S_CLR;
            end
            default: ;
          endcase
        end
      end

      // sweep goto, fail and hit tables back to zero
      S_CLR: begin
        goto_we = 1'b1;
        goto_wa = cnt_r;
        if (cnt_r < GOTO_AW'(MAX_NODES)) begin
          fail_we = 1'b1;
          fail_wa = cnt_r[NODE_W-1:0];
          hits_we = 1'b1;
          hits_wa = cnt_r[NODE_W-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == GOTO_AW'(GOTO_DEPTH - 1)) state_nxt = S_IDLE;
      end

      // trie insert: follow or create the edge
      S_PCHK: begin
        if (goto_rd1 == '0) begin
          if ({1'b0, node_total_r} + 1'b1 >= QCNT_W'(MAX_NODES)) begin
            overflow_nxt = 1'b1;
            drop         = 1'b1;
          end else begin
            node_total_nxt = node_total_r + 1'b1;
            goto_we        = 1'b1;
            goto_wd        = node_total_nxt;
            cur            = node_total_nxt;
          end
        end else begin
          cur = goto_rd1;
        end
        dropping_nxt = drop;
        cursor_nxt   = cur;
        do_close     = last_r;
        state_nxt    = S_IDLE;
      end

      // text: new state, then walk fail chain
      S_TGO: begin
        match_nxt = goto_rd1;
        p_nxt     = goto_rd1;
        hits_ra   = goto_rd1;
        fail_ra   = goto_rd1;
        if (goto_rd1 != '0) state_nxt = S_HUPD;
        else do_text_end = 1'b1;
      end

      S_HUPD: begin
        hits_we = 1'b1;
        hits_wa = p_r;
        hits_wd = (hits_rd == COUNT_MAX) ? hits_rd : hits_rd + 1'b1;
        hits_ra = fail_rd;
        fail_ra = fail_rd;
        p_nxt   = fail_rd;
        if (fail_rd == '0) do_text_end = 1'b1;
      end

      S_TEND: begin
        state_nxt = last_r ? S_RPT : S_IDLE;
      end

      // report start
      S_RPT: begin
        match_nxt = '0;
        best_nxt  = '0;
        lastidx_nxt = '0;
        i_nxt     = '0;
        pass_nxt  = 1'b0;
        cnt_nxt   = '0;
        if (pattern_total_r == '0) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{top_count: '0, pattern_index: '0, overflow: overflow_r,
                            last_result: 1'b1};
          state_nxt     = S_HCLR;
        end else begin
          state_nxt = S_RP;
        end
      end

      S_RP: begin
        state_nxt = S_RH;
      end

      S_RH: begin
        hits_ra   = pend_rd;
        state_nxt = S_RC;
      end

      // compare pass finds the best, emit pass sends matches
      S_RC: begin
        h = hits_rd;
        if (!pass_r) begin
          if (h > best_r) begin
            best_nxt    = h;
            lastidx_nxt = i_r;
          end else if (h == best_r) begin
            lastidx_nxt = i_r;
          end
        end else if (h == best_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{top_count: best_r, pattern_index: i_r + 1'b1,
                            overflow: overflow_r, last_result: (i_r == lastidx_r)};
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_RP;
        if (i_nxt == pattern_total_r) begin
          i_nxt = '0;
          if (!pass_r) pass_nxt = 1'b1;
          else state_nxt = S_HCLR;
        end
      end

      // zero all hit counters
      S_HCLR: begin
        hits_we = 1'b1;
        hits_wa = cnt_r[NODE_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[NODE_W-1:0] == NODE_W'(MAX_NODES - 1)) state_nxt = S_IDLE;
      end

      // build: queue children of the root
      S_BR: begin
        goto_ra1  = GOTO_AW'(c_r);
        state_nxt = S_BRC;
      end

      S_BRC: begin
        if (goto_rd1 != '0 && tail_r < QCNT_W'(MAX_NODES)) begin
          queue_we = 1'b1;
          queue_wd = goto_rd1;
          tail_nxt = tail_r + 1'b1;
        end
        c_nxt     = c_r + 1'b1;
        state_nxt = (c_r == SYM_W'(ALPHABET - 1)) ? S_BH : S_BR;
      end

      // build: breadth-first walk
      S_BH: begin
        if (head_r == tail_r) begin
          state_nxt = S_IDLE;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_BU;
        end
      end

      S_BU: begin
        u_nxt     = queue_rd;
        fail_ra   = queue_rd;
        state_nxt = S_BF;
      end

      S_BF: begin
        f_nxt     = fail_rd;
        c_nxt     = '0;
        state_nxt = S_BE;
      end

      S_BE: begin
        goto_ra1  = row_addr(u_r, c_r);
        goto_ra2  = row_addr(f_r, c_r);
        gaddr_nxt = goto_ra1;
        state_nxt = S_BEC;
      end

      S_BEC: begin
        if (goto_rd1 != '0) begin
          fail_we = 1'b1;
          fail_wa = goto_rd1;
          fail_wd = goto_rd2;
          if (tail_r < QCNT_W'(MAX_NODES)) begin
            queue_we = 1'b1;
            queue_wd = goto_rd1;
            tail_nxt = tail_r + 1'b1;
          end
        end else begin
          goto_we = 1'b1;
          goto_wd = goto_rd2;
        end
        c_nxt     = c_r + 1'b1;
        state_nxt = (c_r == SYM_W'(ALPHABET - 1)) ? S_BH : S_BE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // close the pattern being loaded
    if (do_close) begin
      if (!drop) begin
        if (pattern_total_r >= PAT_W'(MAX_PATTERNS)) begin
          overflow_nxt = 1'b1;
        end else begin
          pend_we           = 1'b1;
          pend_wd           = cur;
          pattern_total_nxt = pattern_total_r + 1'b1;
        end
      end
      dropping_nxt = 1'b0;
      cursor_nxt   = '0;
    end

    // text letter finished
    if (do_text_end) state_nxt = last_r ? S_RPT : S_IDLE;
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLR;
      node_total_r    <= '0;
      pattern_total_r <= '0;
      cursor_r        <= '0;
      match_r         <= '0;
      overflow_r      <= 1'b0;
      built_r         <= 1'b0;
      dropping_r      <= 1'b0;
      cnt_r           <= '0;
      i_r             <= '0;
      pass_r          <= 1'b0;
      c_r             <= '0;
      head_r          <= '0;
      tail_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      node_total_r    <= node_total_nxt;
      pattern_total_r <= pattern_total_nxt;
      cursor_r        <= cursor_nxt;
      match_r         <= match_nxt;
      overflow_r      <= overflow_nxt;
      built_r         <= built_nxt;
      dropping_r      <= dropping_nxt;
      cnt_r           <= cnt_nxt;
      i_r             <= i_nxt;
      pass_r          <= pass_nxt;
      c_r             <= c_nxt;
      head_r          <= head_nxt;
      tail_r          <= tail_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    gaddr_r    <= gaddr_nxt;
    p_r        <= p_nxt;
    best_r     <= best_nxt;
    lastidx_r  <= lastidx_nxt;
    u_r        <= u_nxt;
    f_r        <= f_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, node_total_r} < QCNT_W'(MAX_NODES))
    else $error("node count out of range");

  a_pat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pattern_total_r <= PAT_W'(MAX_PATTERNS))
    else $error("pattern count out of range");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("bfs queue head passed tail");

  a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_result) |=> !out_valid)
    else $error("result after final result");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb
  import mpmc_pkg::*;
;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 3000;

  typedef struct {
    in_t item;
    bit  drain;
  } pend_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  pend_t pending[$];
  out_t  expected_hits[$];
  int    fail_cnt = 0;
  int    gap_cnt = 0;
  bit    burst = 0;
  int    cycles = 0;

  // predictor copy of the automaton
  logic [NODE_W-1:0]     m_goto[GOTO_DEPTH];
  logic [NODE_W-1:0]     m_fail[MAX_NODES];
  logic [COUNT_BITS-1:0] m_hits[MAX_NODES];
  logic [NODE_W-1:0]     m_end[MAX_PATTERNS];
  logic [NODE_W-1:0]     m_bfs[MAX_NODES];
  int m_nodes, m_pats, m_cursor, m_state;
  bit m_ovf, m_built, m_drop;

  multi_pattern_match_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_trie();
    for (int i = 0; i < GOTO_DEPTH; i++) m_goto[i] = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      m_fail[i] = '0;
      m_hits[i] = '0;
    end
    m_nodes = 0;
    m_pats = 0;
    m_cursor = 0;
    m_state = 0;
    m_ovf = 0;
    m_built = 0;
    m_drop = 0;
  endfunction

  function automatic void insert_letter(int sym, bit lst);
    int nxt;
    if (m_built) return;
    if (!m_drop && sym < ALPHABET) begin
      nxt = m_goto[m_cursor*ALPHABET + sym];
      if (nxt == 0) begin
        if (m_nodes + 1 >= MAX_NODES) begin
          m_ovf = 1;
          m_drop = 1;
        end else begin
          m_nodes++;
          nxt = m_nodes;
          m_goto[m_cursor*ALPHABET + sym] = nxt[NODE_W-1:0];
        end
      end
      if (!m_drop) m_cursor = nxt;
    end
    if (lst) begin
      if (!m_drop) begin
        if (m_pats >= MAX_PATTERNS) m_ovf = 1;
        else begin
          m_end[m_pats] = m_cursor[NODE_W-1:0];
          m_pats++;
        end
      end
      m_drop = 0;
      m_cursor = 0;
    end
  endfunction

  // breadth-first fill of fail links and missing edges
  function automatic void build_links();
    int head, tail, u, f, v;
    head = 0;
    tail = 0;
    if (m_built) return;
    m_built = 1;
    for (int c = 0; c < ALPHABET; c++) begin
      v = m_goto[c];
      if (v != 0) begin
        m_bfs[tail] = v[NODE_W-1:0];
        tail++;
      end
    end
    while (head < tail) begin
      u = m_bfs[head];
      head++;
      f = m_fail[u];
      for (int c = 0; c < ALPHABET; c++) begin
        v = m_goto[u*ALPHABET + c];
        if (v != 0) begin
          m_fail[v] = m_goto[f*ALPHABET + c];
          if (tail < MAX_NODES) begin
            m_bfs[tail] = v[NODE_W-1:0];
            tail++;
          end
        end else begin
          m_goto[u*ALPHABET + c] = m_goto[f*ALPHABET + c];
        end
      end
    end
  endfunction

  function automatic void push_hit(int cnt, int idx, bit fin);
    out_t r;
    r.top_count = cnt[COUNT_BITS-1:0];
    r.pattern_index = idx[PAT_W-1:0];
    r.overflow = m_ovf;
    r.last_result = fin;
    expected_hits = {expected_hits, r};
  endfunction

  function automatic void report_top();
    int best, lastidx;
    best = 0;
    lastidx = 0;
    if (m_pats == 0) push_hit(0, 0, 1);
    else begin
      for (int i = 0; i < m_pats; i++)
        if (m_hits[m_end[i]] > best) best = m_hits[m_end[i]];
      for (int i = 0; i < m_pats; i++)
        if (m_hits[m_end[i]] == best) lastidx = i;
      for (int i = 0; i < m_pats; i++)
        if (m_hits[m_end[i]] == best) push_hit(best, i + 1, i == lastidx);
    end
    for (int i = 0; i < MAX_NODES; i++) m_hits[i] = '0;
    m_state = 0;
  endfunction

  function automatic void scan_letter(int sym, bit lst);
    int p, steps;
    if (sym < ALPHABET) begin
      m_state = m_goto[m_state*ALPHABET + sym];
      p = m_state;
      steps = 0;
      while (p != 0 && steps < MAX_NODES) begin
        if (m_hits[p] != '1) m_hits[p] = m_hits[p] + 1'b1;
        p = m_fail[p];
        steps++;
      end
    end else begin
      m_state = 0;
    end
    if (lst) report_top();
  endfunction

  function automatic void predict_item(in_t it);
    case (it.op)
      OP_PATTERN: insert_letter(it.symbol, it.last);
      OP_BUILD:   build_links();
      OP_TEXT:    scan_letter(it.symbol, it.last);
      default:    clear_trie();
    endcase
  endfunction

  function automatic void add_item(op_t op, int sym, bit lst, bit drain = 0);
    pend_t p;
    p.item.op = op;
    p.item.symbol = sym[SYM_W-1:0];
    p.item.last = lst;
    p.drain = drain;
    pending = {pending, p};
  endfunction

  // letters mostly from a small pool so matches overlap
  function automatic int pick_sym();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(0, 3);
    if (r < 19) return $urandom_range(0, 25);
    return $urandom_range(26, 31);
  endfunction

  function automatic void add_string(op_t op, int len);
    if (len == 0) add_item(op, $urandom_range(26, 31), 1);
    for (int i = 0; i < len; i++) add_item(op, pick_sym(), i == len - 1);
  endfunction

  function automatic void add_noise();
    add_item($urandom_range(0, 1) ? OP_BUILD : OP_PATTERN, $urandom_range(0, 31),
             $urandom_range(0, 1));
  endfunction

  function automatic void add_random_phase();
    add_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 1), 1);
    for (int p = $urandom_range(1, 8); p > 0; p--) add_string(OP_PATTERN, $urandom_range(0, 5));
    if ($urandom_range(0, 3) == 0) add_string(OP_TEXT, $urandom_range(1, 6));
    if ($urandom_range(0, 7) != 0) begin
      add_item(OP_BUILD, $urandom_range(0, 31), $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) add_item(OP_BUILD, 0, 0);
    end
    for (int t = 0; t < 4; t++) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      add_string(OP_TEXT, $urandom_range(1, 12));
    end
  endfunction

  // stimulus
  initial begin
    clear_trie();
    // no patterns yet
    add_item(OP_TEXT, 25, 1);
    // patterns: a, z, empty, b followed by an out-of-range letter, ab
    add_item(OP_PATTERN, 0, 1);
    add_item(OP_PATTERN, 25, 1);
    add_item(OP_PATTERN, 31, 1);
    add_item(OP_PATTERN, 1, 0);
    add_item(OP_PATTERN, 26, 1);
    add_item(OP_PATTERN, 0, 0);
    add_item(OP_PATTERN, 1, 1);
    // text before build walks the partial trie
    add_item(OP_TEXT, 0, 0);
    add_item(OP_TEXT, 1, 1);
    add_item(OP_BUILD, 0, 0);
    add_item(OP_BUILD, 31, 1);
    add_item(OP_PATTERN, 2, 1);
    add_item(OP_TEXT, 0, 0);
    add_item(OP_TEXT, 1, 0);
    add_item(OP_TEXT, 16, 0);
    add_item(OP_TEXT, 0, 0);
    add_item(OP_TEXT, 25, 0);
    add_item(OP_TEXT, 0, 0);
    add_item(OP_TEXT, 31, 1);
    add_item(OP_TEXT, 1, 1);

    // pattern slot overflow
    add_item(OP_CLEAR, 5, 1, 1);
    for (int i = 0; i < MAX_PATTERNS + 2; i++) add_item(OP_PATTERN, i % 4, 1);
    add_item(OP_BUILD, 0, 0);
    add_string(OP_TEXT, 10);

    for (int ph = 0; ph < 10; ph++) add_random_phase();

    // reset sequence
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending.size() == 0 && !start);
    wait (expected_hits.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && expected_hits.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // driver with random gaps and burst stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_cnt <= 0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap_cnt > 0) begin
      start <= 1'b0;
      gap_cnt <= gap_cnt - 1;
    end else if (pending.size() != 0 &&
                 (!pending[0].drain || (!start && expected_hits.size() == 0))) begin
      in_item <= pending[0].item;
      start <= 1'b1;
      pending.pop_front();
      if ($urandom_range(0, 19) == 0) burst = !burst;
      gap_cnt <= burst ? 0 : $urandom_range(0, 9);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict accepted items, check results in order
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (start && !busy) predict_item(in_item);
      if (out_valid) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result %p", out_item);
          fail_cnt++;
        end else begin
          want = expected_hits.pop_front();
          if (out_item.top_count !== want.top_count) begin
            $error("top_count: expected %0d, got %0d", want.top_count, out_item.top_count);
            fail_cnt++;
          end
          if (out_item.pattern_index !== want.pattern_index) begin
            $error("pattern_index: expected %0d, got %0d", want.pattern_index,
                   out_item.pattern_index);
            fail_cnt++;
          end
          if (out_item.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_item.overflow);
            fail_cnt++;
          end
          if (out_item.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result,
                   out_item.last_result);
            fail_cnt++;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mpmc_pkg.sv
rtl/multi_pattern_match_counter.sv
test/tb.sv
